/* rtl/assert_macros.svh */
// assertion helpers included by the checker file cp2d_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cp2d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp2d_pkg
// Shared types and constants for the closest pair search block.
// ----------------------------------------------------------------------------
package cp2d_pkg;

  localparam int unsigned CoordInW      = 16;
  localparam int unsigned IndexOutW     = 10;
  localparam int unsigned DistOutW      = 17;
  localparam int unsigned MaxPointsDef  = 1024;
  localparam int unsigned CoordBitsDef  = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_FETCH_I,
    ST_FETCH_J,
    ST_DRAIN,
    ST_SQRT,
    ST_RESULT
  } cp2d_state_e;

  typedef struct packed {
    logic store;
    logic init_scan;
    logic fetch_i;
    logic fetch_j;
    logic next_i;
    logic sqrt_start;
    logic clear;
  } cp2d_cmd_t;

  typedef struct packed {
    logic few;
    logic j_end;
    logic i_end;
    logic pipe_empty;
    logic sqrt_done;
  } cp2d_status_t;

endpackage

/* rtl/cp2d_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp2d_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cp2d_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cp2d_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp2d_isqrt
// Iterative floor integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module cp2d_isqrt #(
  parameter int unsigned InW  = 33,
  parameter int unsigned OutW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [InW-1:0]  value_i,
  output logic            busy_o,
  output logic [OutW-1:0] root_o
);

  localparam int unsigned PadW = 2 * OutW;
  localparam int unsigned CntW = $clog2(OutW + 1);

  logic [PadW-1:0] val_q, val_d;
  logic [OutW-1:0] rem_q, rem_d;
  logic [OutW-1:0] root_q, root_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [OutW+1:0] rem_sh;
  logic [OutW+1:0] trial;
  logic [OutW+1:0] diff;

  assign rem_sh = {rem_q, val_q[PadW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      val_d  = PadW'(value_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(OutW);
    end else if (cnt_q != '0) begin
      val_d = {val_q[PadW-3:0], 2'b00};
      cnt_d = cnt_q - CntW'(1);
      if (rem_sh >= trial) begin
        rem_d  = diff[OutW-1:0];
        root_d = {root_q[OutW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[OutW-1:0];
        root_d = {root_q[OutW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

endmodule

/* rtl/cp2d_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp2d_datapath
// Point store, scan counters, distance pipeline, best pair and square root.
// ----------------------------------------------------------------------------
module cp2d_datapath #(
  parameter int unsigned MaxPoints = cp2d_pkg::MaxPointsDef,
  parameter int unsigned CoordBits = cp2d_pkg::CoordBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cp2d_pkg::cp2d_cmd_t              cmd_i,
  output cp2d_pkg::cp2d_status_t           status_o,
  input  logic [cp2d_pkg::CoordInW-1:0]    x_coord_i,
  input  logic [cp2d_pkg::CoordInW-1:0]    y_coord_i,
  output logic [cp2d_pkg::IndexOutW-1:0]   first_index_o,
  output logic [cp2d_pkg::IndexOutW-1:0]   second_index_o,
  output logic [cp2d_pkg::DistOutW-1:0]    distance_o,
  output logic                             no_pair_o,
  output logic                             overflowed_o
);

  import cp2d_pkg::*;

  localparam int unsigned IdxW   = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW   = $clog2(MaxPoints + 1);
  localparam int unsigned SqW    = 2 * CoordBits + 1;
  localparam int unsigned RootW  = CoordBits + 1;
  localparam int unsigned CWideW = (CoordBits > CoordInW) ? CoordBits : CoordInW;
  localparam int unsigned IWideW = (IdxW > IndexOutW) ? IdxW : IndexOutW;
  localparam int unsigned RWideW = (RootW > DistOutW) ? RootW : DistOutW;

  logic [CntW-1:0]        count_q;
  logic                   dropped_q;
  logic [IdxW-1:0]        i_q;
  logic [IdxW-1:0]        j_q;

  logic [CWideW-1:0]      x_wide, y_wide;
  logic [2*CoordBits-1:0] wdata;
  logic [2*CoordBits-1:0] rdata;
  logic                   we;
  logic                   re;
  logic [IdxW-1:0]        raddr;

  logic                   rd_v_q, rd_is_i_q;
  logic [IdxW-1:0]        rd_idx_q;
  logic [CoordBits-1:0]   px_q, py_q;
  logic [IdxW-1:0]        p_idx_q;
  logic [CoordBits-1:0]   qx, qy;

  logic                   v1_q;
  logic [CoordBits-1:0]   dx_q, dy_q;
  logic [IdxW-1:0]        s1_i_q, s1_j_q;
  logic                   v2_q;
  logic [2*CoordBits-1:0] sqx_q, sqy_q;
  logic [IdxW-1:0]        s2_i_q, s2_j_q;

  logic [SqW-1:0]         sum;
  logic [SqW-1:0]         best_sq_q;
  logic [IdxW-1:0]        best_first_q, best_second_q;

  logic                   sqrt_busy;
  logic [RootW-1:0]       root;
  logic [IWideW-1:0]      first_wide, second_wide;
  logic [RWideW-1:0]      root_wide;

  assign x_wide = CWideW'(x_coord_i);
  assign y_wide = CWideW'(y_coord_i);
  assign wdata  = {x_wide[CoordBits-1:0], y_wide[CoordBits-1:0]};
  assign we     = cmd_i.store && (count_q < CntW'(MaxPoints));
  assign re     = cmd_i.fetch_i || cmd_i.fetch_j;
  assign raddr  = cmd_i.fetch_i ? i_q : j_q;

  cp2d_ram #(
    .Width(2 * CoordBits),
    .Depth(MaxPoints)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // load and scan control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
    end else begin
      if (cmd_i.clear) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
      end else if (cmd_i.store) begin
        if (we) begin
          count_q <= count_q + CntW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (cmd_i.init_scan) begin
        i_q <= '0;
      end else if (cmd_i.next_i) begin
        i_q <= i_q + IdxW'(1);
      end
      if (cmd_i.fetch_i) begin
        j_q <= i_q + IdxW'(1);
      end else if (cmd_i.fetch_j) begin
        j_q <= j_q + IdxW'(1);
      end
    end
  end

  assign status_o.few        = (count_q < CntW'(2));
  assign status_o.j_end      = (CntW'(j_q) == count_q - CntW'(1));
  assign status_o.i_end      = (CntW'(i_q) + CntW'(2) == count_q);
  assign status_o.pipe_empty = !(rd_v_q || v1_q || v2_q);
  assign status_o.sqrt_done  = !sqrt_busy;

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      rd_v_q <= re;
      v1_q   <= rd_v_q && !rd_is_i_q;
      v2_q   <= v1_q;
    end
  end

  assign qx = rdata[2*CoordBits-1:CoordBits];
  assign qy = rdata[CoordBits-1:0];

  // read tag, difference and square stages
  always_ff @(posedge clk_i) begin
    rd_is_i_q <= cmd_i.fetch_i;
    rd_idx_q  <= raddr;
    if (rd_v_q && rd_is_i_q) begin
      px_q    <= qx;
      py_q    <= qy;
      p_idx_q <= rd_idx_q;
    end
    dx_q   <= (px_q >= qx) ? (px_q - qx) : (qx - px_q);
    dy_q   <= (py_q >= qy) ? (py_q - qy) : (qy - py_q);
    s1_i_q <= p_idx_q;
    s1_j_q <= rd_idx_q;
    sqx_q  <= dx_q * dx_q;
    sqy_q  <= dy_q * dy_q;
    s2_i_q <= s1_i_q;
    s2_j_q <= s1_j_q;
  end

  assign sum = SqW'(sqx_q) + SqW'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_sq_q     <= '1;
      best_first_q  <= '0;
      best_second_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        best_sq_q     <= '1;
        best_first_q  <= '0;
        best_second_q <= '0;
      end else if (v2_q && (sum < best_sq_q)) begin
        best_sq_q     <= sum;
        best_first_q  <= s2_i_q;
        best_second_q <= s2_j_q;
      end
    end
  end

  cp2d_isqrt #(
    .InW (SqW),
    .OutW(RootW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sqrt_start),
    .value_i(best_sq_q),
    .busy_o (sqrt_busy),
    .root_o (root)
  );

  assign first_wide  = IWideW'(best_first_q);
  assign second_wide = IWideW'(best_second_q);
  assign root_wide   = RWideW'(root);

  assign no_pair_o      = status_o.few;
  assign overflowed_o   = dropped_q;
  assign first_index_o  = status_o.few ? '0 : first_wide[IndexOutW-1:0];
  assign second_index_o = status_o.few ? '0 : second_wide[IndexOutW-1:0];
  assign distance_o     = status_o.few ? '0 : root_wide[DistOutW-1:0];

endmodule

/* rtl/cp2d_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp2d_ctrl
// Sequencer for point loading, the pairwise scan, square root and output.
// ----------------------------------------------------------------------------
module cp2d_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   last_point_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output cp2d_pkg::cp2d_cmd_t    cmd_o,
  input  cp2d_pkg::cp2d_status_t status_i
);

  import cp2d_pkg::*;

  cp2d_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (last_point_i) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        if (status_i.few) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.init_scan = 1'b1;
          state_d         = ST_FETCH_I;
        end
      end
      ST_FETCH_I: begin
        cmd_o.fetch_i = 1'b1;
        state_d       = ST_FETCH_J;
      end
      ST_FETCH_J: begin
        cmd_o.fetch_j = 1'b1;
        if (status_i.j_end) begin
          if (status_i.i_end) begin
            state_d = ST_DRAIN;
          end else begin
            cmd_o.next_i = 1'b1;
            state_d      = ST_FETCH_I;
          end
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (status_i.sqrt_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

/* rtl/closest_pair_2d.sv */
// sequence: one point per cycle while loading; after the last point a setup state,
// then the pairwise scan, which reads point i and then each later point j from the
// store, the pipeline drain and the bit-serial square root, after which the result
// shows; with no pair the setup state goes straight to the result
// throughput: one set at a time, bounded by the single read port of the store
// reset: asynchronous, clears counts and flags; the point store is not cleared
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_2d
// Loads 2D points and reports the closest pair and its distance.
// ----------------------------------------------------------------------------
module closest_pair_2d #(
  parameter int unsigned MAX_POINTS = cp2d_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = cp2d_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cp2d_pkg::CoordInW-1:0]  x_coord_i,
  input  logic [cp2d_pkg::CoordInW-1:0]  y_coord_i,
  input  logic                           last_point_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cp2d_pkg::IndexOutW-1:0] first_index_o,
  output logic [cp2d_pkg::IndexOutW-1:0] second_index_o,
  output logic [cp2d_pkg::DistOutW-1:0]  distance_o,
  output logic                           no_pair_o,
  output logic                           overflowed_o
);

  import cp2d_pkg::*;

  cp2d_cmd_t    cmd;
  cp2d_status_t status;

  cp2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_point_i(last_point_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  cp2d_datapath #(
    .MaxPoints(MAX_POINTS),
    .CoordBits(COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .first_index_o (first_index_o),
    .second_index_o(second_index_o),
    .distance_o    (distance_o),
    .no_pair_o     (no_pair_o),
    .overflowed_o  (overflowed_o)
  );

endmodule

/* rtl/cp2d_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp2d_checker
// Port-level checks for the closest pair block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cp2d_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [cp2d_pkg::IndexOutW-1:0] first_index_o,
  input logic [cp2d_pkg::IndexOutW-1:0] second_index_o,
  input logic [cp2d_pkg::DistOutW-1:0]  distance_o,
  input logic                           no_pair_o
);

  `CP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `CP_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(distance_o) && $stable(first_index_o) && $stable(second_index_o), "stalled result changed")
  `CP_ASSERT_NOW(a_no_input_on_result, out_valid_o, in_stall_o, "input taken while result pending")
  `CP_ASSERT_NOW(a_no_pair_zero, out_valid_o && no_pair_o, first_index_o == '0 && second_index_o == '0 && distance_o == '0, "no pair result not zero")

endmodule

bind closest_pair_2d cp2d_checker u_cp2d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .first_index_o (first_index_o),
  .second_index_o(second_index_o),
  .distance_o    (distance_o),
  .no_pair_o     (no_pair_o)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for closest_pair_2d. Sends point sets over the input
// channel and predicts the closest pair, its indices, its floor distance and
// the no-pair and overflow flags for each set. Every result is compared with
// the prediction in order. The bench starts with a directed table of extreme
// and corner cases. Random sets follow under three idle profiles, with one
// long output hold. A set then runs past the store capacity; four more sets follow.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned StoreDepth = cp2d_pkg::MaxPointsDef;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned PhasePoints = 120;
  localparam int unsigned MaxPrinted = 40;

  typedef struct packed {
    logic [cp2d_pkg::IndexOutW-1:0] first_idx;
    logic [cp2d_pkg::IndexOutW-1:0] second_idx;
    logic [cp2d_pkg::DistOutW-1:0]  dist_val;
    logic                           no_pair;
    logic                           ovf;
  } pair_result_t;

  typedef struct packed {
    logic [cp2d_pkg::CoordInW-1:0] x;
    logic [cp2d_pkg::CoordInW-1:0] y;
    logic                          last;
    logic                          has_fixed;
    pair_result_t                  fixed_res;
  } stim_row_t;

  // rows with has_fixed set carry a hand-written result, the rest use the predictor
  localparam int unsigned DirRows = 21;
  localparam stim_row_t DirTbl [DirRows] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, '{10'd0, 10'd0, 17'd0, 1'b1, 1'b0}},
    '{16'h0000, 16'h0000, 1'b0, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{10'd0, 10'd1, 17'd92680, 1'b0, 1'b0}},
    '{16'hFFFF, 16'h0000, 1'b0, 1'b0, '0},
    '{16'h0000, 16'hFFFF, 1'b1, 1'b1, '{10'd0, 10'd1, 17'd92680, 1'b0, 1'b0}},
    '{16'h1234, 16'h5678, 1'b0, 1'b0, '0},
    '{16'h1234, 16'h5678, 1'b1, 1'b1, '{10'd0, 10'd1, 17'd0, 1'b0, 1'b0}},
    '{16'd0,    16'd0,    1'b0, 1'b0, '0},
    '{16'd3,    16'd4,    1'b0, 1'b0, '0},
    '{16'd6,    16'd8,    1'b1, 1'b0, '0},
    '{16'hAAAA, 16'h5555, 1'b0, 1'b0, '0},
    '{16'h5555, 16'hAAAA, 1'b0, 1'b0, '0},
    '{16'hAAAA, 16'h5556, 1'b0, 1'b0, '0},
    '{16'h5555, 16'hAAAB, 1'b1, 1'b0, '0},
    '{16'd100,  16'd200,  1'b0, 1'b0, '0},
    '{16'd900,  16'd900,  1'b0, 1'b0, '0},
    '{16'd105,  16'd210,  1'b0, 1'b0, '0},
    '{16'd905,  16'd902,  1'b0, 1'b0, '0},
    '{16'd101,  16'd201,  1'b1, 1'b0, '0},
    '{16'hFFFF, 16'h0000, 1'b0, 1'b0, '0},
    '{16'hFFFF, 16'h0001, 1'b1, 1'b1, '{10'd0, 10'd1, 17'd1, 1'b0, 1'b0}}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [cp2d_pkg::CoordInW-1:0]  x_coord_i = '0;
  logic [cp2d_pkg::CoordInW-1:0]  y_coord_i = '0;
  logic                           last_point_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [cp2d_pkg::IndexOutW-1:0] first_index_o;
  logic [cp2d_pkg::IndexOutW-1:0] second_index_o;
  logic [cp2d_pkg::DistOutW-1:0]  distance_o;
  logic                           no_pair_o;
  logic                           overflowed_o;

  closest_pair_2d dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .last_point_i   (last_point_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .first_index_o  (first_index_o),
    .second_index_o (second_index_o),
    .distance_o     (distance_o),
    .no_pair_o      (no_pair_o),
    .overflowed_o   (overflowed_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state: one point set in arrival order
  logic [cp2d_pkg::CoordInW-1:0] set_x [StoreDepth];
  logic [cp2d_pkg::CoordInW-1:0] set_y [StoreDepth];
  int unsigned                   set_count = 0;
  bit                            set_dropped = 1'b0;

  pair_result_t pending_pairs [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned holds_taken = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned points_sent = 0;
  int unsigned sets_sent = 0;
  int unsigned set_len = 0;
  int unsigned largest_set = 0;
  int unsigned overflow_sets = 0;
  int unsigned results_checked = 0;

  function automatic logic [cp2d_pkg::DistOutW-1:0] floor_sqrt(input logic [33:0] v);
    logic [cp2d_pkg::DistOutW-1:0] root;
    logic [33:0]                   trial;
    root = '0;
    for (int b = cp2d_pkg::DistOutW - 1; b >= 0; b--) begin
      trial = 34'(root) | (34'd1 << b);
      if (trial * trial <= v) begin
        root = trial[cp2d_pkg::DistOutW-1:0];
      end
    end
    return root;
  endfunction

  // stores or drops one point; on the last point searches all pairs and clears the set
  function automatic bit store_and_search(input logic [cp2d_pkg::CoordInW-1:0] x,
                                          input logic [cp2d_pkg::CoordInW-1:0] y,
                                          input logic last,
                                          output pair_result_t res);
    logic [33:0] best;
    logic [33:0] dx;
    logic [33:0] dy;
    logic [33:0] sq;
    int unsigned bi;
    int unsigned bj;
    res = '0;
    if (set_count < StoreDepth) begin
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) begin
      return 1'b0;
    end
    best = '1;
    bi = 0;
    bj = 0;
    for (int unsigned i = 0; i < set_count; i++) begin
      for (int unsigned j = i + 1; j < set_count; j++) begin
        dx = 34'((set_x[i] >= set_x[j]) ? set_x[i] - set_x[j] : set_x[j] - set_x[i]);
        dy = 34'((set_y[i] >= set_y[j]) ? set_y[i] - set_y[j] : set_y[j] - set_y[i]);
        sq = dx * dx + dy * dy;
        if (sq < best) begin
          best = sq;
          bi = i;
          bj = j;
        end
      end
    end
    if (set_count < 2) begin
      res.no_pair = 1'b1;
    end else begin
      res.first_idx = bi[cp2d_pkg::IndexOutW-1:0];
      res.second_idx = bj[cp2d_pkg::IndexOutW-1:0];
      res.dist_val = floor_sqrt(best);
    end
    res.ovf = set_dropped;
    set_count = 0;
    set_dropped = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MaxPrinted) begin
      $display("tb_top: mismatch in %s at cycle %0d: got %0d, expected %0d",
               what, cycle_cnt, got, want);
    end
  endtask

  // one input transaction, then the prediction it causes
  task automatic send_point(input logic [cp2d_pkg::CoordInW-1:0] x,
                            input logic [cp2d_pkg::CoordInW-1:0] y,
                            input logic last,
                            input logic has_fixed,
                            input pair_result_t fixed_res);
    pair_result_t calc;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    last_point_i <= last;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    points_sent++;
    set_len++;
    if (store_and_search(x, y, last, calc)) begin
      pending_pairs.insert(pending_pairs.size(), has_fixed ? fixed_res : calc);
      sets_sent++;
      if (calc.ovf) begin
        overflow_sets++;
      end
      if (set_len > largest_set) begin
        largest_set = set_len;
      end
      set_len = 0;
    end
  endtask

  task automatic send_random_set(input int unsigned n_pts);
    logic [cp2d_pkg::CoordInW-1:0] bx;
    logic [cp2d_pkg::CoordInW-1:0] by;
    logic [cp2d_pkg::CoordInW-1:0] px;
    logic [cp2d_pkg::CoordInW-1:0] py;
    int unsigned                   style;
    style = $urandom_range(3);
    bx = 16'($urandom);
    by = 16'($urandom);
    px = 16'($urandom);
    py = 16'($urandom);
    for (int unsigned k = 0; k < n_pts; k++) begin
      case (style)
        0: begin
          px = 16'($urandom);
          py = 16'($urandom);
        end
        1: begin
          px = bx + 16'($urandom_range(15));
          py = by + 16'($urandom_range(15));
        end
        2: begin
          px = {16{1'($urandom_range(1))}} ^ 16'($urandom_range(3));
          py = {16{1'($urandom_range(1))}} ^ 16'($urandom_range(3));
        end
        default: begin
          // repeat the previous point now and then, else a coarse grid
          if (k == 0 || $urandom_range(2) != 0) begin
            px = 16'($urandom_range(7) * 9000);
            py = 16'($urandom_range(7) * 9000);
          end
        end
      endcase
      send_point(px, py, k == n_pts - 1, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_top: timeout after %0d cycles", cycle_cnt);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // output stall: random, or a long counted hold when requested
  always @(posedge clk_i) begin
    if (hold_reqs != holds_taken) begin
      holds_taken = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    pair_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        want = pending_pairs.pop_front();
        results_checked++;
        if (first_index_o !== want.first_idx) begin
          report_mismatch("first_index", 32'(first_index_o), 32'(want.first_idx));
        end
        if (second_index_o !== want.second_idx) begin
          report_mismatch("second_index", 32'(second_index_o), 32'(want.second_idx));
        end
        if (distance_o !== want.dist_val) begin
          report_mismatch("distance", 32'(distance_o), 32'(want.dist_val));
        end
        if (no_pair_o !== want.no_pair) begin
          report_mismatch("no_pair", 32'(no_pair_o), 32'(want.no_pair));
        end
        if (overflowed_o !== want.ovf) begin
          report_mismatch("overflowed", 32'(overflowed_o), 32'(want.ovf));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned                   target;
    int unsigned                   n_pts;
    logic [cp2d_pkg::CoordInW-1:0] fx;
    logic [cp2d_pkg::CoordInW-1:0] fy;
    logic [cp2d_pkg::CoordInW-1:0] px;
    logic [cp2d_pkg::CoordInW-1:0] py;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      send_point(DirTbl[r].x, DirTbl[r].y, DirTbl[r].last, DirTbl[r].has_fixed,
                 DirTbl[r].fixed_res);
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 56 : 0;
      rx_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 27 : 0;
      target = points_sent + PhasePoints;
      if (ph == 2) begin
        // result held back while the next set waits at the stalled input
        send_random_set(5);
        hold_reqs++;
      end
      while (points_sent < target) begin
        n_pts = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
        send_random_set(n_pts);
      end
    end

    // more points than the store holds; dropped ones copy the first point
    fx = 16'($urandom);
    fy = 16'($urandom);
    for (int unsigned k = 0; k < StoreDepth + 6; k++) begin
      if (k == 0 || k >= StoreDepth) begin
        px = fx;
        py = fy;
      end else begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
      send_point(px, py, k == StoreDepth + 5, 1'b0, '0);
    end

    tx_idle_pct = 0;
    for (int s = 0; s < 4; s++) begin
      send_random_set($urandom_range(2, 6));
    end
    in_valid_i <= 1'b0;

    while (pending_pairs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb_top: %0d points in %0d sets, %0d results checked, largest set %0d",
             points_sent, sets_sent, results_checked, largest_set);
    $display("tb_top: three idle profiles, one long output hold, %0d set(s) past capacity",
             overflow_sets);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* closest_pair_2d.f */
+incdir+rtl
rtl/cp2d_pkg.sv
rtl/cp2d_ram.sv
rtl/cp2d_isqrt.sv
rtl/cp2d_datapath.sv
rtl/cp2d_ctrl.sv
rtl/closest_pair_2d.sv
rtl/cp2d_checker.sv
sim/tb_top.sv
